@@ hdl/quaternion_to_euler_angles_assert.svh @@
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - assertion macros
// Concurrent assertion shorthands on clk with reset rst.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// same-cycle implication
`define Q2E_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define Q2E_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - package
// Widths, pipeline depths, CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 2;
  localparam int ISQ_BITS      = 31;
  localparam int VW            = 2 * ISQ_BITS;
  localparam int OPW           = 35;
  localparam int NW            = 41;
  localparam int CW            = 45;
  localparam int ANGW          = 32;
  localparam int PIPE_LAT      = 6 + ISQ_BITS + CORDIC_LAT;

  localparam logic signed [ANGW-1:0] HALF_PI     = 32'sd421657428;
  localparam logic signed [ANGW-1:0] ANGLE_LIMIT = 32'sd25736;
  localparam logic signed [ANGW-1:0] ASIN_LIMIT  = 32'sd12868;

  // atan(2^-i) in units of 2^-28 rad
  function automatic logic signed [ANGW-1:0] atan_tbl(input int i);
    logic signed [ANGW-1:0] r;
    case (i)
      0:       r = 32'sd210828714;
      1:       r = 32'sd124459457;
      2:       r = 32'sd65760959;
      3:       r = 32'sd33381290;
      4:       r = 32'sd16755422;
      5:       r = 32'sd8385879;
      6:       r = 32'sd4193963;
      7:       r = 32'sd2097109;
      8:       r = 32'sd1048571;
      9:       r = 32'sd524287;
      10:      r = 32'sd262144;
      11:      r = 32'sd131072;
      12:      r = 32'sd65536;
      13:      r = 32'sd32768;
      14:      r = 32'sd16384;
      15:      r = 32'sd8192;
      16:      r = 32'sd4096;
      17:      r = 32'sd2048;
      18:      r = 32'sd1024;
      19:      r = 32'sd512;
      20:      r = 32'sd256;
      21:      r = 32'sd128;
      22:      r = 32'sd64;
      23:      r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

  // atan2 operands carried alongside the asin path
  typedef struct packed {
    logic signed [OPW-1:0] zy;
    logic signed [OPW-1:0] zx;
    logic signed [OPW-1:0] xy;
    logic signed [OPW-1:0] xx;
    logic                  zero;
  } ops_t;

  typedef struct packed {
    logic                  neg;
    logic [ISQ_BITS-1:0]   sm;
  } asin_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [14:0] y;
    logic signed [15:0] x;
    logic               zero;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/q2e_ifs.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - stream interfaces
// Valid/ready channels for the quaternion input and the angle output.
// ----------------------------------------------------------------------------
`default_nettype none

interface q2e_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] z_rotation_angle;
  logic signed [14:0] y_rotation_angle;
  logic signed [15:0] x_rotation_angle;
  logic               zero_norm;
  modport source (output valid, z_rotation_angle, y_rotation_angle, x_rotation_angle,
                  zero_norm, input ready);
  modport sink   (input valid, z_rotation_angle, y_rotation_angle, x_rotation_angle,
                  zero_norm, output ready);
endinterface

`default_nettype wire

@@ hdl/quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - top level
// Raw Q2.14 quaternion in, ZYX Euler angles in Q3.13 radians out (y in Q2.13).
// ----------------------------------------------------------------------------
// Usage:
//   quat  : request with w, x, y, z in signed Q2.14, taken on valid && ready.
//   euler : request with the z, y and x rotation angles (radians; z and x Q3.13, y Q2.13) and
//           zero_norm, delivered on valid && ready, one per quaternion, in order.
//   From acceptance to euler.valid a quaternion passes the products, sums and
//   asin scaling, the square root (one root bit per stage) and the CORDIC
//   (scale, fold, 16 stages). Throughput is one quaternion per cycle while
//   the output buffer has room; every stage advances together.
//   A two-entry output buffer follows the pipeline; the pipeline holds only
//   when both entries are full, so a quaternion is still taken while one
//   finished result waits. When euler.ready stays low the buffer fills, the
//   pipeline holds and quat.ready drops; nothing is lost or repeated.
//   Reset (rst, synchronous) clears the valid bits and the buffer; the first
//   quaternion can be taken in the cycle after reset is released.
//   An all-zero quaternion gives zero angles with zero_norm set.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_angles (
  input  wire logic      clk,
  input  wire logic      rst,
  q2e_quat_if.sink       quat,
  q2e_euler_if.source    euler
);
  import q2e_pkg::*;

  logic en, push, pop;
  logic [1:0] cnt, cnt_next;
  logic wp, rp;
  res_t obuf [0:1];
  res_t res_c;

  logic vld [0:PIPE_LAT-1];

  // stage 1 products
  logic signed [31:0] ww1, xx1, yy1, zz1, wx1, wy1, wz1, xy1, xz1, yz1;
  logic               zero1;
  // stage 2 sums
  ops_t               ops2, ops3, ops4, ops5, ops6;
  logic signed [OPW-1:0] n2, s2, sa3;
  // stage 3..6 asin scaling
  logic [32:0]        n3, sm3, nsh, ssh;
  logic               neg3;
  logic [5:0]         msb3;
  logic [5:0]         msb_c;
  asin_t              as4, as5, as6;
  logic [ISQ_BITS-1:0] n4;
  logic [VW-1:0]      nn5, ss5, v6;

  ops_t               ops_d [0:ISQ_BITS-1];
  asin_t              as_d  [0:ISQ_BITS-1];
  logic               zero_d [0:CORDIC_LAT-1];
  logic [ISQ_BITS-1:0] root;

  logic signed [OPW-1:0]  asin_y, asin_x;
  logic signed [ANGW-1:0] z_ang, y_ang, x_ang;

  // advance whenever the output buffer has room; take nothing during reset
  assign en         = (cnt != 2'd2);
  assign quat.ready = en && !rst;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= quat.valid;
      for (int i = 1; i < PIPE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      ww1   <= quat.quat_w * quat.quat_w;
      xx1   <= quat.quat_x * quat.quat_x;
      yy1   <= quat.quat_y * quat.quat_y;
      zz1   <= quat.quat_z * quat.quat_z;
      wx1   <= quat.quat_w * quat.quat_x;
      wy1   <= quat.quat_w * quat.quat_y;
      wz1   <= quat.quat_w * quat.quat_z;
      xy1   <= quat.quat_x * quat.quat_y;
      xz1   <= quat.quat_x * quat.quat_z;
      yz1   <= quat.quat_y * quat.quat_z;
      zero1 <= (quat.quat_w == '0) && (quat.quat_x == '0) &&
               (quat.quat_y == '0) && (quat.quat_z == '0);
    end
  end

  // atan2 operands, norm and asin numerator
  always_ff @(posedge clk) begin
    if (en) begin
      ops2.zy   <= (OPW'(xy1) + OPW'(wz1)) <<< 1;
      ops2.zx   <= OPW'(ww1) + OPW'(xx1) - OPW'(yy1) - OPW'(zz1);
      ops2.xy   <= (OPW'(wx1) + OPW'(yz1)) <<< 1;
      ops2.xx   <= OPW'(ww1) - OPW'(xx1) - OPW'(yy1) + OPW'(zz1);
      ops2.zero <= zero1;
      n2        <= OPW'(ww1) + OPW'(xx1) + OPW'(yy1) + OPW'(zz1);
      s2        <= (OPW'(wy1) - OPW'(xz1)) <<< 1;
    end
  end

  // clamp |s| to n and locate the leading one of n
  always_comb begin
    sa3   = s2[OPW-1] ? -s2 : s2;
    msb_c = '0;
    for (int i = 0; i < 33; i++) begin
      if (n2[i]) msb_c = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops3 <= ops2;
      n3   <= n2[32:0];
      sm3  <= (sa3[32:0] > n2[32:0]) ? n2[32:0] : sa3[32:0];
      neg3 <= s2[OPW-1];
      msb3 <= msb_c;
    end
  end

  // bring n into [2^30, 2^31) and scale |s| with it
  always_comb begin
    if (msb3 >= 6'd31) begin
      nsh = n3 >> (msb3 - 6'd30);
      ssh = sm3 >> (msb3 - 6'd30);
    end else begin
      nsh = n3 << (6'd30 - msb3);
      ssh = sm3 << (6'd30 - msb3);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ops4   <= ops3;
      n4     <= nsh[ISQ_BITS-1:0];
      as4.sm <= ssh[ISQ_BITS-1:0];
      as4.neg <= neg3;
    end
  end

  // squares, then n^2 - s^2
  always_ff @(posedge clk) begin
    if (en) begin
      ops5 <= ops4;
      as5  <= as4;
      nn5  <= VW'(n4) * VW'(n4);
      ss5  <= VW'(as4.sm) * VW'(as4.sm);
      ops6 <= ops5;
      as6  <= as5;
      v6   <= nn5 - ss5;
    end
  end

  q2e_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .v_in (v6),
    .root (root)
  );

  // hold the other operands while the root is formed
  always_ff @(posedge clk) begin
    if (en) begin
      ops_d[0] <= ops6;
      as_d[0]  <= as6;
      for (int i = 1; i < ISQ_BITS; i++) begin
        ops_d[i] <= ops_d[i-1];
        as_d[i]  <= as_d[i-1];
      end
    end
  end

  assign asin_y = as_d[ISQ_BITS-1].neg ? -OPW'(as_d[ISQ_BITS-1].sm)
                                       : OPW'(as_d[ISQ_BITS-1].sm);
  assign asin_x = OPW'(root);

  q2e_cordic u_cordic_z (
    .clk (clk), .en (en),
    .y_in (ops_d[ISQ_BITS-1].zy), .x_in (ops_d[ISQ_BITS-1].zx),
    .angle (z_ang)
  );

  q2e_cordic u_cordic_y (
    .clk (clk), .en (en),
    .y_in (asin_y), .x_in (asin_x),
    .angle (y_ang)
  );

  q2e_cordic u_cordic_x (
    .clk (clk), .en (en),
    .y_in (ops_d[ISQ_BITS-1].xy), .x_in (ops_d[ISQ_BITS-1].xx),
    .angle (x_ang)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      zero_d[0] <= ops_d[ISQ_BITS-1].zero;
      for (int i = 1; i < CORDIC_LAT; i++) zero_d[i] <= zero_d[i-1];
    end
  end

  // round half up to Q3.13 and saturate
  function automatic logic signed [ANGW-1:0] rnd_sat(input logic signed [ANGW-1:0] a,
                                                     input logic signed [ANGW-1:0] lim);
    logic signed [ANGW-1:0] r;
    r = (a + 32'sd16384) >>> 15;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  always_comb begin
    res_c.zero = zero_d[CORDIC_LAT-1];
    res_c.z    = 16'(rnd_sat(z_ang, ANGLE_LIMIT));
    res_c.y    = 15'(rnd_sat(y_ang, ASIN_LIMIT));
    res_c.x    = 16'(rnd_sat(x_ang, ANGLE_LIMIT));
    if (res_c.zero) begin
      res_c.z = '0;
      res_c.y = '0;
      res_c.x = '0;
    end
  end

  // output buffer
  assign push = en && vld[PIPE_LAT-1];
  assign pop  = euler.valid && euler.ready;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
    end
  end

  always_ff @(posedge clk) begin
    if (push) obuf[wp] <= res_c;
  end

  assign euler.valid            = (cnt != 2'd0);
  assign euler.z_rotation_angle = obuf[rp].z;
  assign euler.y_rotation_angle = obuf[rp].y;
  assign euler.x_rotation_angle = obuf[rp].x;
  assign euler.zero_norm        = obuf[rp].zero;

`include "quaternion_to_euler_angles_assert.svh"

  `Q2E_ASSERT_IMP(a_full_hold, cnt == 2'd2, !quat.ready && !push, "request taken while output buffer full")
  `Q2E_ASSERT_IMP(a_cnt_max, 1'b1, cnt != 2'd3, "output buffer count out of range")
  `Q2E_ASSERT_IMP(a_zero_angles, euler.valid && euler.zero_norm, euler.z_rotation_angle == 16'sd0 && euler.y_rotation_angle == 15'sd0 && euler.x_rotation_angle == 16'sd0, "zero quaternion with nonzero angle")
  `Q2E_ASSERT_IMP(a_y_range, euler.valid, euler.y_rotation_angle <= 15'sd12868 && euler.y_rotation_angle >= -15'sd12868, "y angle beyond half pi")
  `Q2E_ASSERT_NXT(a_drain, cnt == 2'd1 && pop && !push, cnt == 2'd0, "output buffer failed to drain")

endmodule

`default_nettype wire

@@ hdl/q2e_isqrt.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - pipelined integer square root
// Truncated square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_isqrt (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [q2e_pkg::VW-1:0]        v_in,
  output logic      [q2e_pkg::ISQ_BITS-1:0]  root
);
  import q2e_pkg::*;

  logic [VW:0]         rem_r [0:ISQ_BITS-1];
  logic [ISQ_BITS-1:0] q_r   [0:ISQ_BITS-1];

  for (genvar j = 0; j < ISQ_BITS; j++) begin : g_bit
    localparam int K = ISQ_BITS - 1 - j;
    logic [VW:0]         rem_in;
    logic [ISQ_BITS-1:0] q_in;
    logic [VW:0]         trial;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, v_in};
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
    end

    // (q + 2^k)^2 - q^2
    assign trial = ((VW+1)'(q_in) << (K + 1)) + ((VW+1)'(1) << (2 * K));

    // set bit k where the remainder allows it
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[j] <= rem_in - trial;
          q_r[j]   <= q_in | (ISQ_BITS'(1) << K);
        end else begin
          rem_r[j] <= rem_in;
          q_r[j]   <= q_in;
        end
      end
    end
  end

  assign root = q_r[ISQ_BITS-1];

endmodule

`default_nettype wire

@@ hdl/q2e_cordic.sv @@
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - pipelined CORDIC atan2
// Scale, quadrant fold, then one vectoring micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [q2e_pkg::OPW-1:0]    y_in,
  input  wire logic signed [q2e_pkg::OPW-1:0]    x_in,
  output logic      signed [q2e_pkg::ANGW-1:0]   angle
);
  import q2e_pkg::*;

  logic [OPW-1:0] ay_c, ax_c, m_c;
  logic [5:0]     msb_c, sh_c;
  logic [OPW-1:0] ay_a, ax_a;
  logic           ys_a, xs_a, zero_a;
  logic [5:0]     sh_a;

  logic [NW-1:0]         ay_l, ax_l;
  logic signed [CW-1:0]  yv, xv, x0_c, y0_c;
  logic signed [ANGW-1:0] z0_c;

  logic signed [CW-1:0]   cx [0:CORDIC_STAGES];
  logic signed [CW-1:0]   cy [0:CORDIC_STAGES];
  logic signed [ANGW-1:0] cz [0:CORDIC_STAGES];
  logic                   cn [0:CORDIC_STAGES];

  // magnitudes and scale shift
  always_comb begin
    ay_c  = y_in[OPW-1] ? OPW'(-y_in) : OPW'(y_in);
    ax_c  = x_in[OPW-1] ? OPW'(-x_in) : OPW'(x_in);
    m_c   = (ay_c > ax_c) ? ay_c : ax_c;
    msb_c = '0;
    for (int i = 0; i < OPW; i++) begin
      if (m_c[i]) msb_c = 6'(i);
    end
    sh_c = 6'(NW - 1) - msb_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ay_a   <= ay_c;
      ax_a   <= ax_c;
      ys_a   <= y_in[OPW-1];
      xs_a   <= x_in[OPW-1];
      sh_a   <= sh_c;
      zero_a <= (m_c == '0);
    end
  end

  // scale, reapply signs, fold into the right half plane
  always_comb begin
    ay_l = {(NW-OPW)'(0), ay_a} << sh_a;
    ax_l = {(NW-OPW)'(0), ax_a} << sh_a;
    yv   = ys_a ? -$signed({(CW-NW)'(0), ay_l}) : $signed({(CW-NW)'(0), ay_l});
    xv   = xs_a ? -$signed({(CW-NW)'(0), ax_l}) : $signed({(CW-NW)'(0), ax_l});
    x0_c = xv;
    y0_c = yv;
    z0_c = '0;
    if (xv[CW-1]) begin
      if (!yv[CW-1]) begin
        x0_c = yv;
        y0_c = -xv;
        z0_c = HALF_PI;
      end else begin
        x0_c = -yv;
        y0_c = xv;
        z0_c = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= x0_c;
      cy[0] <= y0_c;
      cz[0] <= z0_c;
      cn[0] <= zero_a;
    end
  end

  // micro-rotations toward y = 0
  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[gi][CW-1]) begin
          cx[gi+1] <= cx[gi] + (cy[gi] >>> gi);
          cy[gi+1] <= cy[gi] - (cx[gi] >>> gi);
          cz[gi+1] <= cz[gi] + atan_tbl(gi);
        end else begin
          cx[gi+1] <= cx[gi] - (cy[gi] >>> gi);
          cy[gi+1] <= cy[gi] + (cx[gi] >>> gi);
          cz[gi+1] <= cz[gi] - atan_tbl(gi);
        end
        cn[gi+1] <= cn[gi];
      end
    end
  end

  // both operands zero gives zero angle
  assign angle = cn[CORDIC_STAGES] ? '0 : cz[CORDIC_STAGES];

endmodule

`default_nettype wire
